>>> src/sbxd_pkg.sv
`timescale 1ns / 1ps
// Package: shared types and constants of the start-byte XOR packet deframer.
package sbxd_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int POS_W         = 4;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;

    typedef logic [7:0]         byte_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic signed [15:0] class_id_t;
    typedef logic [31:0]        angle_bits_t;
    typedef logic signed [15:0] action_code_t;
    typedef logic [PAYLOAD_W-1:0] payload_t;

    localparam byte_t START_MARKER_RESET = 8'd170;
    // byte position at which the checksum byte is expected
    localparam pos_t  POS_CKSUM          = POS_W'(PAYLOAD_BYTES);

endpackage

>>> src/sbxd_in_if.sv
`timescale 1ns / 1ps
// Interface: received byte channel.
interface sbxd_in_if
    import sbxd_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> src/sbxd_out_if.sv
`timescale 1ns / 1ps
// Interface: decoded packet result channel.
interface sbxd_out_if
    import sbxd_pkg::*;
();
    logic         valid;
    logic         ready;
    class_id_t    class_id;
    angle_bits_t  angle_bits;
    action_code_t action_code;

    modport source (output valid, output class_id, output angle_bits, output action_code,
                    input ready);
    modport sink   (input valid, input class_id, input angle_bits, input action_code,
                    output ready);
endinterface

>>> src/start_byte_xor_packet_deframer_top.sv
`timescale 1ns / 1ps
// Top level: start-byte framed packet deframer with XOR checksum check.
//
//  channel   | dir | payload                               | handshake
//  ----------+-----+---------------------------------------+-------------------
//  rx_ch     | in  | rx_byte                               | valid/ready
//  res_ch    | out | class_id, angle_bits, action_code     | valid/ready
//  cfg       | in  | cfg_wdata (start marker)              | cfg_we, no stall
//
//  One item per cycle while the input stage does not hold; an accepted good checksum byte
//  passes the input register, then the result register loads the result and raises valid.
//  The input stage holds only while a good checksum byte waits for a full result register.
//  Reset: hunting for the start byte, start marker 170, no result pending.

module start_byte_xor_packet_deframer_top
    import sbxd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  byte_t             cfg_wdata,
    sbxd_in_if.sink           rx_ch,
    sbxd_out_if.source        res_ch
);

    byte_t        start_marker_reg;
    logic         in_valid_reg;
    byte_t        in_byte_reg;
    logic         in_packet_reg;
    pos_t         byte_pos_reg;
    byte_t        xor_reg;
    payload_t     payload_reg;
    logic         out_valid_reg;
    class_id_t    class_id_reg;
    angle_bits_t  angle_bits_reg;
    action_code_t action_code_reg;

    logic         in_packet_next;
    pos_t         byte_pos_next;
    byte_t        xor_next;
    payload_t     payload_next;

    logic is_cksum;
    logic emit;
    logic out_free;
    logic consume;

    assign is_cksum = in_packet_reg && (byte_pos_reg == POS_CKSUM);
    assign emit     = in_valid_reg && is_cksum && (in_byte_reg == xor_reg);
    assign out_free = !out_valid_reg || res_ch.ready;
    assign consume  = in_valid_reg && (!emit || out_free);

    assign rx_ch.ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RESET;
        end
        else if (cfg_we)
        begin
            start_marker_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_ch.ready)
        begin
            in_valid_reg <= rx_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ch.valid && rx_ch.ready)
        begin
            in_byte_reg <= rx_ch.rx_byte;
        end
    end

    always_comb
    begin
        in_packet_next = in_packet_reg;
        byte_pos_next  = byte_pos_reg;
        xor_next       = xor_reg;
        payload_next   = payload_reg;
        if (!in_packet_reg)
        begin
            if (in_byte_reg == start_marker_reg)
            begin
                in_packet_next = 1'b1;
                byte_pos_next  = '0;
                xor_next       = '0;
            end
        end
        else if (!is_cksum)
        begin
            payload_next[{byte_pos_reg[2:0], 3'b000} +: 8] = in_byte_reg;
            xor_next      = xor_reg ^ in_byte_reg;
            byte_pos_next = byte_pos_reg + pos_t'(1);
        end
        else
        begin
            in_packet_next = 1'b0;
            byte_pos_next  = '0;
            xor_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            byte_pos_reg  <= '0;
            xor_reg       <= '0;
        end
        else if (consume)
        begin
            in_packet_reg <= in_packet_next;
            byte_pos_reg  <= byte_pos_next;
            xor_reg       <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            payload_reg <= payload_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit && consume)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload is little-endian: bytes 0-1 class, 2-5 angle, 6-7 action
    always_ff @(posedge clk)
    begin
        if (emit && consume)
        begin
            class_id_reg    <= class_id_t'(payload_reg[15:0]);
            angle_bits_reg  <= payload_reg[47:16];
            action_code_reg <= action_code_t'(payload_reg[63:48]);
        end
    end

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.class_id    = class_id_reg;
    assign res_ch.angle_bits  = angle_bits_reg;
    assign res_ch.action_code = action_code_reg;

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pos_reg <= POS_CKSUM)
        else $error("byte position past checksum slot");

    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !in_packet_reg |-> (byte_pos_reg == '0) && (xor_reg == '0))
        else $error("packet state not cleared while hunting");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit && consume |=> out_valid_reg)
        else $error("good packet did not reach result register");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !consume |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input item lost");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_ch.ready |=> out_valid_reg && $stable(class_id_reg)
            && $stable(angle_bits_reg) && $stable(action_code_reg))
        else $error("pending result overwritten");
`endif

endmodule
